### src/hkm_pkg.sv
// ----------------------------------------------------------------------------
// hkm_pkg
// Types, codes and the entry ordering shared by the merge engine and its cells.
// ----------------------------------------------------------------------------
package hkm_pkg;

	localparam int HEAP_DEPTH   = 64;
	localparam int COLUMN_WIDTH = 16;
	localparam int VALUE_WIDTH  = 32;
	localparam int ROW_WIDTH    = 6;
	localparam int COUNT_WIDTH  = $clog2(HEAP_DEPTH + 1);

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_REPLACE = 2'd1;
	localparam logic [1:0] CMD_REMOVE  = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_FULL  = 2'd1;
	localparam logic [1:0] FAULT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT_INSERT,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0]  value;
		logic        [ROW_WIDTH-1:0]    row;
		logic        [COLUMN_WIDTH-1:0] column;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   item;
	} cell_ctrl_t;

	typedef struct packed {
		logic        [1:0]              command;
		logic signed [VALUE_WIDTH-1:0]  value;
		logic        [ROW_WIDTH-1:0]    row;
		logic        [COLUMN_WIDTH-1:0] column;
	} cmd_word_t;

	typedef struct packed {
		logic                           popped_valid;
		logic signed [VALUE_WIDTH-1:0]  popped_value;
		logic        [ROW_WIDTH-1:0]    popped_row;
		logic        [COLUMN_WIDTH-1:0] popped_column;
		logic                           top_valid;
		logic signed [VALUE_WIDTH-1:0]  top_value;
		logic        [ROW_WIDTH-1:0]    top_row;
		logic        [COLUMN_WIDTH-1:0] top_column;
		logic        [COUNT_WIDTH-1:0]  entry_count;
		logic        [1:0]              fault;
	} res_word_t;

	// True when entry a must sit above entry b: greater value, then lower row,
	// then lower column.
	function automatic logic outranks(entry_t a, entry_t b);
		logic result;
		if (a.value != b.value) begin
			result = (a.value > b.value);
		end else if (a.row != b.row) begin
			result = (a.row < b.row);
		end else begin
			result = (a.column < b.column);
		end
		return result;
	endfunction

endpackage

### src/heap_kway_merge_engine.sv
// ----------------------------------------------------------------------------
// heap_kway_merge_engine
// Max-priority queue of tagged entries for merging sorted rows.
// ----------------------------------------------------------------------------
// Commands arrive as words on the cmd channel (cmd_valid, cmd_stall, cmd_word)
// and each gives exactly one result word on the res channel (res_valid,
// res_stall, res_word). A command loads an entry, replaces the top entry with a
// new one from the same row, or removes the top entry.
// Entries sit in a row of cells kept in descending order, cell zero holding the
// top. Every command updates all cells in a single cycle, each cell comparing
// the new entry with its own and taking its neighbour's entry where needed.
// The result word is registered from cell zero once the result register is
// free, and one command can be accepted every cycle while the result register
// keeps draining.
// When the receiver stalls, the finished result is held in the output register
// and one further command may complete into the pending stage; cmd_stall then
// rises until the result register frees.
// Reset empties the queue at once; the cell contents are not cleared and are
// never shown while they lie beyond the entry count.
// ----------------------------------------------------------------------------
module heap_kway_merge_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  hkm_pkg::cmd_word_t  cmd_word,
	output logic                res_valid,
	input  logic                res_stall,
	output hkm_pkg::res_word_t  res_word
);

	localparam int CW = hkm_pkg::COUNT_WIDTH;

	hkm_pkg::entry_t    cell_entry [hkm_pkg::HEAP_DEPTH];
	logic               cell_gt    [hkm_pkg::HEAP_DEPTH];
	hkm_pkg::cell_ctrl_t ctrl;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               pend_q;
	logic               res_valid_q;
	hkm_pkg::res_word_t res_word_q;

	logic               pop_valid_s1;
	hkm_pkg::entry_t    pop_entry_s1;
	logic [1:0]         fault_s1;

	logic               accept;
	logic               out_free;
	logic               full;
	logic               empty;
	logic               popped;
	logic [1:0]         fault;

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = pend_q && !out_free;
	assign accept    = cmd_valid && !cmd_stall;
	assign full      = (count_q == CW'(hkm_pkg::HEAP_DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		ctrl.op          = hkm_pkg::OP_HOLD;
		ctrl.item.value  = cmd_word.value;
		ctrl.item.row    = cmd_word.row;
		ctrl.item.column = cmd_word.column;
		count_next       = count_q;
		popped           = 1'b0;
		fault            = hkm_pkg::FAULT_NONE;
		unique case (cmd_word.command) inside
			hkm_pkg::CMD_LOAD: begin
				if (full) begin
					fault = hkm_pkg::FAULT_FULL;
				end else begin
					ctrl.op    = hkm_pkg::OP_INSERT;
					count_next = count_q + CW'(1);
				end
			end
			hkm_pkg::CMD_REPLACE, hkm_pkg::CMD_REMOVE: begin
				if (empty) begin
					fault = hkm_pkg::FAULT_EMPTY;
				end else begin
					popped = 1'b1;
					if (cmd_word.command == hkm_pkg::CMD_REPLACE) begin
						ctrl.op       = hkm_pkg::OP_SHIFT_INSERT;
						ctrl.item.row = cell_entry[0].row;
					end else begin
						ctrl.op    = hkm_pkg::OP_SHIFT;
						count_next = count_q - CW'(1);
					end
				end
			end
			hkm_pkg::CMD_NOP: begin
				fault = hkm_pkg::FAULT_NONE;
			end
		endcase
		if (!accept) begin
			ctrl.op    = hkm_pkg::OP_HOLD;
			count_next = count_q;
		end
	end

	for (genvar i = 0; i < hkm_pkg::HEAP_DEPTH; i++) begin : g_cell
		hkm_pkg::entry_t left_e;
		hkm_pkg::entry_t right_e;
		logic            left_g;
		logic            base_valid;

		if (i == 0) begin : g_first
			assign left_e = cell_entry[i];
			assign left_g = 1'b0;
		end else begin : g_inner_left
			assign left_e = cell_entry[i-1];
			assign left_g = cell_gt[i-1];
		end

		if (i == hkm_pkg::HEAP_DEPTH - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner_right
			assign right_e = cell_entry[i+1];
		end

		assign base_valid = (ctrl.op == hkm_pkg::OP_SHIFT_INSERT) ?
			(count_q > CW'(i + 1)) : (count_q > CW'(i));

		hkm_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_gt     (left_g),
			.base_valid  (base_valid),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				pend_q <= 1'b1;
			end else if (out_free) begin
				pend_q <= 1'b0;
			end
			if (out_free) begin
				res_valid_q <= pend_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_valid_s1 <= popped;
			pop_entry_s1 <= popped ? cell_entry[0] : '0;
			fault_s1     <= fault;
		end
		if (pend_q && out_free) begin
			res_word_q.popped_valid  <= pop_valid_s1;
			res_word_q.popped_value  <= pop_entry_s1.value;
			res_word_q.popped_row    <= pop_entry_s1.row;
			res_word_q.popped_column <= pop_entry_s1.column;
			res_word_q.top_valid     <= !empty;
			res_word_q.top_value     <= empty ? '0 : cell_entry[0].value;
			res_word_q.top_row       <= empty ? '0 : cell_entry[0].row;
			res_word_q.top_column    <= empty ? '0 : cell_entry[0].column;
			res_word_q.entry_count   <= count_q;
			res_word_q.fault         <= fault_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

### src/hkm_cell.sv
// ----------------------------------------------------------------------------
// hkm_cell
// One slot of the sorted entry row: holds an entry and, on each command,
// keeps it, takes a neighbour's entry or takes the broadcast item.
// ----------------------------------------------------------------------------
module hkm_cell (
	input  logic              clk,
	input  hkm_pkg::cell_ctrl_t ctrl,
	input  hkm_pkg::entry_t   left_entry,
	input  hkm_pkg::entry_t   right_entry,
	input  logic              left_gt,
	input  logic              base_valid,
	output hkm_pkg::entry_t   entry,
	output logic              gt
);

	hkm_pkg::entry_t entry_q;
	hkm_pkg::entry_t entry_next;
	hkm_pkg::entry_t base_cur;
	hkm_pkg::entry_t base_prev;
	logic            shifted;

	always_comb begin
		shifted   = (ctrl.op == hkm_pkg::OP_SHIFT_INSERT);
		base_cur  = shifted ? right_entry : entry_q;
		base_prev = shifted ? entry_q : left_entry;
		gt        = !base_valid || hkm_pkg::outranks(ctrl.item, base_cur);
	end

	always_comb begin
		case (ctrl.op) inside
			hkm_pkg::OP_INSERT, hkm_pkg::OP_SHIFT_INSERT: begin
				if (gt) begin
					entry_next = left_gt ? base_prev : ctrl.item;
				end else begin
					entry_next = base_cur;
				end
			end
			hkm_pkg::OP_SHIFT: begin
				entry_next = right_entry;
			end
			default: begin
				entry_next = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_next;
	end

	assign entry = entry_q;

endmodule
